// ===== rtl/bilinear_table_lookup_unit_macros.svh =====
// Assertion macros for the bilinear table lookup unit.
// Used by bilinear_table_lookup_unit.sv; needs clk and rst_n in scope.
`ifndef BILINEAR_TABLE_LOOKUP_UNIT_MACROS_SVH
`define BILINEAR_TABLE_LOOKUP_UNIT_MACROS_SVH
`ifndef SYNTH
`define BTLU_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bilinear_table_lookup_unit: check failed");
`define BTLU_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bilinear_table_lookup_unit: check failed");
`else
`define BTLU_ASSERT_NOW(lbl, pre, post)
`define BTLU_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/btl_pkg.sv =====
// Shared types and constants of the bilinear table lookup unit.
// No dependencies; used by bilinear_table_lookup_unit.
package btl_pkg;

    localparam int MAX_POINTS  = 8;
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int TADDR_W     = 2 * IDX_W;
    localparam int TABLE_DEPTH = MAX_POINTS * MAX_POINTS;
    localparam int SIZE_W      = 4;
    localparam int FUNC_W      = 2;
    localparam int ADDR_W      = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int STAT_W      = 2;

    localparam int QUO_W   = VALUE_WIDTH + FRAC_BITS;
    localparam int FRAC_W  = QUO_W + 1;
    localparam int CNT_W   = $clog2(QUO_W);
    localparam int ROW_W   = 57;
    localparam int CHUNK_W = 16;
    localparam int NCHUNK  = (QUO_W + CHUNK_W - 1) / CHUNK_W;
    localparam int MCNT_W  = $clog2(NCHUNK);
    localparam int MF_W    = NCHUNK * CHUNK_W;
    localparam int ACC_W   = ROW_W + MF_W;
    localparam int MAG_W   = 62;
    localparam int SUM_W   = 64;

    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 40;

    localparam logic signed [SUM_W-1:0] RES_MAX =
        {{(SUM_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ROW_MAX =
        {{(SUM_W-ROW_W+1){1'b0}}, {(ROW_W-1){1'b1}}};

    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_SIZE = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WR_SLEW  = 2'd0,
        FUNC_WR_LOAD  = 2'd1,
        FUNC_WR_TABLE = 2'd2,
        FUNC_LOOKUP   = 2'd3
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_SAT  = 2'd1,
        STAT_ZERO = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        PH_ROW_A,
        PH_ROW_B,
        PH_FINAL
    } phase_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SR_FIRST,
        ST_SR_LAST,
        ST_SR_MID,
        ST_LO_RD,
        ST_HI_RD,
        ST_DIV,
        ST_DIV_END,
        ST_TRD0,
        ST_TRD1,
        ST_TRD2,
        ST_FIN_SET,
        ST_MUL,
        ST_RND,
        ST_ADD,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/btl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bilinear_table_lookup_unit.sv =====
// Bilinear table lookup unit: axis and table storage, segment search, divider,
// chunked multiplier and saturating interpolation under one sequencer.
// Depends on btl_pkg, btl_ram and bilinear_table_lookup_unit_macros.svh.
//
// Usage:
//   Input words arrive on s_axis_*; tuser carries the function code. Writes to
//   the slew axis, load axis or table give no output word.
//   A lookup gives one output word on m_axis_*: result value and status.
//   Sizes are set on the cfg_* channel (index 0 slew size, 1 load size),
//   always ready; the user must set them only while no lookup is in flight,
//   and the block itself does not enforce this. A lookup runs a setup step,
//   then for each axis of size above one a segment search, two axis reads,
//   a divide and a hand-over step, then one table-row step, or two if slew
//   size > 1, and a final step.
//   The divider and the multiplier are each used once per step in turn, so one
//   lookup is in flight at a time; s_axis_tready is low until it completes.
//   The result waits in an output register; a stalled receiver holds it, and
//   the next word is still accepted; a second lookup waits at its end.
//   Reset sets both sizes to 1 and clears the output valid; axis and table contents
//   are undefined until written.
`include "bilinear_table_lookup_unit_macros.svh"

module bilinear_table_lookup_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // tdata: write_addr[5:0], write_value[37:6], query_slew[69:38],
    //        query_load[101:70], zero fill
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [btl_pkg::S_DATA_W-1:0]     s_axis_tdata,
    // tuser: func[1:0]
    input  logic [btl_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: result_value[31:0], status[33:32], zero fill
    output logic [btl_pkg::M_DATA_W-1:0]     m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [btl_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [btl_pkg::SIZE_W-1:0]       cfg_data
);

    localparam int VW = btl_pkg::VALUE_WIDTH;
    localparam int RW = btl_pkg::ROW_W;
    localparam int SW = btl_pkg::SUM_W;

    btl_pkg::state_t state_reg, state_next;
    btl_pkg::phase_t phase_reg, phase_next;

    logic [btl_pkg::SIZE_W-1:0] slew_size_reg, load_size_reg;
    logic [btl_pkg::SIZE_W-1:0] n_slew, n_load, n_cur;

    logic signed [VW-1:0] slew_ax_reg [btl_pkg::MAX_POINTS];
    logic signed [VW-1:0] load_ax_reg [btl_pkg::MAX_POINTS];

    logic signed [VW-1:0] qslew_reg, qslew_next, qload_reg, qload_next;
    logic signed [VW-1:0] xl_reg, xl_next;
    logic                 axis_sel_reg, axis_sel_next;
    logic [btl_pkg::IDX_W-1:0] k_reg, k_next, idx_reg, idx_next;
    logic [btl_pkg::IDX_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [VW-1:0]        ud_reg, ud_next, r_reg, r_next;
    logic [btl_pkg::QUO_W-1:0] dq_reg, dq_next;
    logic                 fneg_reg, fneg_next;
    logic [btl_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [btl_pkg::FRAC_W-1:0] dx1_reg, dx1_next, dx2_reg, dx2_next;
    logic                 zero_reg, zero_next, sat_reg, sat_next;

    logic signed [RW-1:0] op_a_reg, op_a_next, ra_reg, ra_next, rb_reg, rb_next;
    logic [RW-1:0]        ud_mul_reg, ud_mul_next;
    logic [btl_pkg::MF_W-1:0] mf_reg, mf_next;
    logic                 pneg_reg, pneg_next;
    logic [btl_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [btl_pkg::MCNT_W-1:0] mcnt_reg, mcnt_next;
    logic [btl_pkg::MAG_W-1:0] mag_reg, mag_next;

    logic signed [VW-1:0] res_reg, res_next;
    btl_pkg::stat_t       stat_reg, stat_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 s_acc;
    btl_pkg::func_t       in_func;
    logic [btl_pkg::ADDR_W-1:0] in_addr;
    logic signed [VW-1:0] in_value, in_qslew, in_qload, qx, ax_rd;
    logic [btl_pkg::IDX_W-1:0] ax_rd_addr, nm2, row_sel;

    logic                 ram_we;
    logic [btl_pkg::TADDR_W-1:0] ram_waddr, ram_raddr;
    logic [VW-1:0]        ram_rdata;

    logic signed [VW:0]   num_d, den_d, num_abs, den_abs;
    logic [VW:0]          div_sh, div_trial;
    logic                 div_ge;
    logic signed [btl_pkg::FRAC_W-1:0] quo_s, mul_f, f_abs;
    logic signed [RW-1:0] mul_a, mul_b;
    logic signed [RW:0]   d_full, d_abs;
    logic [RW+btl_pkg::CHUNK_W-1:0] mul_prod;
    logic [btl_pkg::ACC_W-1:0] acc_step;
    logic [btl_pkg::ACC_W:0] rnd_sum;
    logic [btl_pkg::ACC_W-btl_pkg::FRAC_BITS:0] rnd_m;
    logic                 rnd_ovf;
    logic signed [SW-1:0] mag_ext, delta, add_sum, lim;
    logic                 add_hi, add_lo;
    logic signed [SW-1:0] add_res;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign in_func  = btl_pkg::func_t'(s_axis_tuser);
    assign in_addr  = s_axis_tdata[btl_pkg::ADDR_W-1:0];
    assign in_value = s_axis_tdata[btl_pkg::ADDR_W +: VW];
    assign in_qslew = s_axis_tdata[btl_pkg::ADDR_W+VW +: VW];
    assign in_qload = s_axis_tdata[btl_pkg::ADDR_W+2*VW +: VW];

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(btl_pkg::M_DATA_W-VW-btl_pkg::STAT_W){1'b0}}, stat_reg, res_reg};

    assign n_slew = (slew_size_reg == '0) ? btl_pkg::SIZE_W'(1) :
                    (slew_size_reg > btl_pkg::SIZE_W'(btl_pkg::MAX_POINTS)) ?
                    btl_pkg::SIZE_W'(btl_pkg::MAX_POINTS) : slew_size_reg;
    assign n_load = (load_size_reg == '0) ? btl_pkg::SIZE_W'(1) :
                    (load_size_reg > btl_pkg::SIZE_W'(btl_pkg::MAX_POINTS)) ?
                    btl_pkg::SIZE_W'(btl_pkg::MAX_POINTS) : load_size_reg;
    assign n_cur  = axis_sel_reg ? n_load : n_slew;
    assign qx     = axis_sel_reg ? qload_reg : qslew_reg;
    assign nm2    = btl_pkg::IDX_W'(n_cur - btl_pkg::SIZE_W'(2));
    assign ax_rd  = axis_sel_reg ? load_ax_reg[ax_rd_addr] : slew_ax_reg[ax_rd_addr];

    assign num_d     = {qx[VW-1], qx} - {xl_reg[VW-1], xl_reg};
    assign den_d     = {ax_rd[VW-1], ax_rd} - {xl_reg[VW-1], xl_reg};
    assign num_abs   = num_d[VW] ? -num_d : num_d;
    assign den_abs   = den_d[VW] ? -den_d : den_d;
    assign div_sh    = {r_reg, dq_reg[btl_pkg::QUO_W-1]};
    assign div_trial = div_sh - {1'b0, ud_reg};
    assign div_ge    = !div_trial[VW];
    assign quo_s     = fneg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});

    assign mul_f    = (phase_reg == btl_pkg::PH_FINAL) ? dx1_reg : dx2_reg;
    assign f_abs    = mul_f[btl_pkg::FRAC_W-1] ? -mul_f : mul_f;
    assign d_full   = {mul_b[RW-1], mul_b} - {mul_a[RW-1], mul_a};
    assign d_abs    = d_full[RW] ? -d_full : d_full;
    assign mul_prod = ud_mul_reg * mf_reg[btl_pkg::MF_W-1 -: btl_pkg::CHUNK_W];
    assign acc_step = (acc_reg << btl_pkg::CHUNK_W) + btl_pkg::ACC_W'(mul_prod);
    assign rnd_sum  = {1'b0, acc_reg} + (btl_pkg::ACC_W+1)'(1 << (btl_pkg::FRAC_BITS-1));
    assign rnd_m    = rnd_sum[btl_pkg::ACC_W:btl_pkg::FRAC_BITS];
    assign rnd_ovf  = |rnd_m[btl_pkg::ACC_W-btl_pkg::FRAC_BITS:btl_pkg::MAG_W];
    assign mag_ext  = SW'(mag_reg);
    assign delta    = pneg_reg ? -mag_ext : mag_ext;
    assign add_sum  = SW'(op_a_reg) + delta;
    assign lim      = (phase_reg == btl_pkg::PH_FINAL) ? btl_pkg::RES_MAX : btl_pkg::ROW_MAX;
    assign add_hi   = add_sum > lim;
    assign add_lo   = add_sum < ~lim;
    assign add_res  = add_hi ? lim : (add_lo ? ~lim : add_sum);

    assign row_sel  = (phase_reg == btl_pkg::PH_ROW_B) ? i_reg + 1'b1 : i_reg;

    btl_ram #(
        .WIDTH(VW),
        .DEPTH(btl_pkg::TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(in_value),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // outputs of the sequencer
    always_comb
    begin
        s_axis_tready = (state_reg == btl_pkg::ST_IDLE);
        ram_we        = (state_reg == btl_pkg::ST_IDLE) && s_acc &&
                        (in_func == btl_pkg::FUNC_WR_TABLE);
        ram_waddr     = in_addr[btl_pkg::TADDR_W-1:0];
        ram_raddr     = {row_sel, j_reg + (state_reg == btl_pkg::ST_TRD1 ?
                         btl_pkg::IDX_W'(1) : btl_pkg::IDX_W'(0))};
        mul_a         = ra_reg;
        mul_b         = (n_slew > btl_pkg::SIZE_W'(1)) ? rb_reg : ra_reg;
        if (state_reg == btl_pkg::ST_TRD2)
        begin
            mul_a = op_a_reg;
            mul_b = RW'($signed(ram_rdata));
        end
        case (state_reg)
            btl_pkg::ST_SR_FIRST: ax_rd_addr = '0;
            btl_pkg::ST_SR_LAST:  ax_rd_addr = btl_pkg::IDX_W'(n_cur - btl_pkg::SIZE_W'(1));
            btl_pkg::ST_SR_MID:   ax_rd_addr = k_reg;
            btl_pkg::ST_LO_RD:    ax_rd_addr = idx_reg;
            btl_pkg::ST_HI_RD:    ax_rd_addr = idx_reg + 1'b1;
            default:              ax_rd_addr = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            btl_pkg::ST_IDLE:
                if (s_acc && in_func == btl_pkg::FUNC_LOOKUP)
                    state_next = btl_pkg::ST_SETUP;
            btl_pkg::ST_SETUP:
                if (n_slew > btl_pkg::SIZE_W'(1) || n_load > btl_pkg::SIZE_W'(1))
                    state_next = btl_pkg::ST_SR_FIRST;
                else
                    state_next = btl_pkg::ST_TRD0;
            btl_pkg::ST_SR_FIRST:
                state_next = (qx <= ax_rd) ? btl_pkg::ST_LO_RD : btl_pkg::ST_SR_LAST;
            btl_pkg::ST_SR_LAST:
                state_next = (qx >= ax_rd || n_cur == btl_pkg::SIZE_W'(2)) ?
                             btl_pkg::ST_LO_RD : btl_pkg::ST_SR_MID;
            btl_pkg::ST_SR_MID:
                if (ax_rd >= qx || k_reg == nm2)
                    state_next = btl_pkg::ST_LO_RD;
            btl_pkg::ST_LO_RD:
                state_next = btl_pkg::ST_HI_RD;
            btl_pkg::ST_HI_RD:
                state_next = (den_d == '0) ? btl_pkg::ST_DIV_END : btl_pkg::ST_DIV;
            btl_pkg::ST_DIV:
                if (cnt_reg == btl_pkg::CNT_W'(btl_pkg::QUO_W-1))
                    state_next = btl_pkg::ST_DIV_END;
            btl_pkg::ST_DIV_END:
                state_next = (!axis_sel_reg && n_load > btl_pkg::SIZE_W'(1)) ?
                             btl_pkg::ST_SR_FIRST : btl_pkg::ST_TRD0;
            btl_pkg::ST_TRD0:
                state_next = btl_pkg::ST_TRD1;
            btl_pkg::ST_TRD1:
                state_next = btl_pkg::ST_TRD2;
            btl_pkg::ST_TRD2:
                state_next = btl_pkg::ST_MUL;
            btl_pkg::ST_FIN_SET:
                state_next = btl_pkg::ST_MUL;
            btl_pkg::ST_MUL:
                if (mcnt_reg == btl_pkg::MCNT_W'(btl_pkg::NCHUNK-1))
                    state_next = btl_pkg::ST_RND;
            btl_pkg::ST_RND:
                state_next = btl_pkg::ST_ADD;
            btl_pkg::ST_ADD:
                if (phase_reg == btl_pkg::PH_FINAL)
                    state_next = btl_pkg::ST_DONE;
                else if (phase_reg == btl_pkg::PH_ROW_A && n_slew > btl_pkg::SIZE_W'(1))
                    state_next = btl_pkg::ST_TRD0;
                else
                    state_next = btl_pkg::ST_FIN_SET;
            btl_pkg::ST_DONE:
                if (!out_valid_reg || m_axis_tready)
                    state_next = btl_pkg::ST_IDLE;
            default:
                state_next = btl_pkg::ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb
    begin
        phase_next     = phase_reg;
        qslew_next     = qslew_reg;
        qload_next     = qload_reg;
        xl_next        = xl_reg;
        axis_sel_next  = axis_sel_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        ud_next        = ud_reg;
        r_next         = r_reg;
        dq_next        = dq_reg;
        fneg_next      = fneg_reg;
        cnt_next       = cnt_reg;
        dx1_next       = dx1_reg;
        dx2_next       = dx2_reg;
        zero_next      = zero_reg;
        sat_next       = sat_reg;
        op_a_next      = op_a_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        ud_mul_next    = ud_mul_reg;
        mf_next        = mf_reg;
        pneg_next      = pneg_reg;
        acc_next       = acc_reg;
        mcnt_next      = mcnt_reg;
        mag_next       = mag_reg;
        res_next       = res_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        case (state_reg)
            btl_pkg::ST_IDLE:
            begin
                qslew_next    = in_qslew;
                qload_next    = in_qload;
                phase_next    = btl_pkg::PH_ROW_A;
                axis_sel_next = 1'b0;
                i_next        = '0;
                j_next        = '0;
                dx1_next      = '0;
                dx2_next      = '0;
                zero_next     = 1'b0;
                sat_next      = 1'b0;
            end
            btl_pkg::ST_SETUP:
                axis_sel_next = !(n_slew > btl_pkg::SIZE_W'(1));
            btl_pkg::ST_SR_FIRST:
                idx_next = '0;
            btl_pkg::ST_SR_LAST:
            begin
                idx_next = nm2;
                k_next   = btl_pkg::IDX_W'(1);
            end
            btl_pkg::ST_SR_MID:
            begin
                idx_next = (ax_rd >= qx) ? k_reg - 1'b1 : nm2;
                k_next   = k_reg + 1'b1;
            end
            btl_pkg::ST_LO_RD:
                xl_next = ax_rd;
            btl_pkg::ST_HI_RD:
            begin
                ud_next   = den_abs[VW-1:0];
                r_next    = '0;
                cnt_next  = '0;
                dq_next   = {num_abs[VW-1:0], {btl_pkg::FRAC_BITS{1'b0}}};
                fneg_next = num_d[VW] ^ den_d[VW];
                if (den_d == '0)
                begin
                    zero_next = 1'b1;
                    dq_next   = '0;
                    fneg_next = 1'b0;
                end
            end
            btl_pkg::ST_DIV:
            begin
                r_next   = div_ge ? div_trial[VW-1:0] : div_sh[VW-1:0];
                dq_next  = {dq_reg[btl_pkg::QUO_W-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            btl_pkg::ST_DIV_END:
            begin
                if (!axis_sel_reg)
                begin
                    dx1_next      = quo_s;
                    i_next        = idx_reg;
                    axis_sel_next = 1'b1;
                end
                else
                begin
                    dx2_next = quo_s;
                    j_next   = idx_reg;
                end
            end
            btl_pkg::ST_TRD1:
                op_a_next = RW'($signed(ram_rdata));
            btl_pkg::ST_TRD2, btl_pkg::ST_FIN_SET:
            begin
                op_a_next   = mul_a;
                ud_mul_next = d_abs[RW-1:0];
                mf_next     = btl_pkg::MF_W'(f_abs[btl_pkg::QUO_W-1:0]);
                pneg_next   = d_full[RW] ^ mul_f[btl_pkg::FRAC_W-1];
                acc_next    = '0;
                mcnt_next   = '0;
            end
            btl_pkg::ST_MUL:
            begin
                acc_next  = acc_step;
                mf_next   = mf_reg << btl_pkg::CHUNK_W;
                mcnt_next = mcnt_reg + 1'b1;
            end
            btl_pkg::ST_RND:
            begin
                mag_next = rnd_ovf ? {btl_pkg::MAG_W{1'b1}} : rnd_m[btl_pkg::MAG_W-1:0];
                if (rnd_ovf)
                    sat_next = 1'b1;
            end
            btl_pkg::ST_ADD:
            begin
                if (add_hi || add_lo)
                    sat_next = 1'b1;
                case (phase_reg)
                    btl_pkg::PH_ROW_A:
                    begin
                        ra_next    = RW'(add_res);
                        phase_next = (n_slew > btl_pkg::SIZE_W'(1)) ?
                                     btl_pkg::PH_ROW_B : btl_pkg::PH_FINAL;
                    end
                    btl_pkg::PH_ROW_B:
                    begin
                        rb_next    = RW'(add_res);
                        phase_next = btl_pkg::PH_FINAL;
                    end
                    default:
                        op_a_next = RW'(add_res);
                endcase
            end
            btl_pkg::ST_DONE:
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    res_next       = VW'(op_a_reg);
                    stat_next      = zero_reg ? btl_pkg::STAT_ZERO :
                                     (sat_reg ? btl_pkg::STAT_SAT : btl_pkg::STAT_OK);
                end
            default:
                out_valid_next = out_valid_reg && !m_axis_tready;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= btl_pkg::ST_IDLE;
            phase_reg     <= btl_pkg::PH_ROW_A;
            slew_size_reg <= btl_pkg::SIZE_W'(1);
            load_size_reg <= btl_pkg::SIZE_W'(1);
            axis_sel_reg  <= 1'b0;
            k_reg         <= '0;
            cnt_reg       <= '0;
            mcnt_reg      <= '0;
            zero_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            axis_sel_reg  <= axis_sel_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
            mcnt_reg      <= mcnt_next;
            zero_reg      <= zero_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_addr == btl_pkg::CFG_SLEW_SIZE)
                    slew_size_reg <= cfg_data;
                if (cfg_addr == btl_pkg::CFG_LOAD_SIZE)
                    load_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        qslew_reg  <= qslew_next;
        qload_reg  <= qload_next;
        xl_reg     <= xl_next;
        idx_reg    <= idx_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        ud_reg     <= ud_next;
        r_reg      <= r_next;
        dq_reg     <= dq_next;
        fneg_reg   <= fneg_next;
        dx1_reg    <= dx1_next;
        dx2_reg    <= dx2_next;
        op_a_reg   <= op_a_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        ud_mul_reg <= ud_mul_next;
        mf_reg     <= mf_next;
        pneg_reg   <= pneg_next;
        acc_reg    <= acc_next;
        mag_reg    <= mag_next;
        res_reg    <= res_next;
        stat_reg   <= stat_next;
        if (state_reg == btl_pkg::ST_IDLE && s_acc &&
            in_addr[btl_pkg::ADDR_W-1:btl_pkg::IDX_W] == '0)
        begin
            if (in_func == btl_pkg::FUNC_WR_SLEW)
                slew_ax_reg[in_addr[btl_pkg::IDX_W-1:0]] <= in_value;
            if (in_func == btl_pkg::FUNC_WR_LOAD)
                load_ax_reg[in_addr[btl_pkg::IDX_W-1:0]] <= in_value;
        end
    end

    `BTLU_ASSERT_NEXT(a_lookup_holds_input, s_acc && in_func == btl_pkg::FUNC_LOOKUP, !s_axis_tready)
    `BTLU_ASSERT_NOW(a_divisor_nonzero, state_reg == btl_pkg::ST_DIV, ud_reg != '0)
    `BTLU_ASSERT_NOW(a_search_in_range, state_reg == btl_pkg::ST_SR_MID, k_reg != '0 && k_reg <= nm2)
    `BTLU_ASSERT_NEXT(a_result_from_done, !out_valid_reg && state_reg != btl_pkg::ST_DONE, !m_axis_tvalid)

endmodule
